// ===== hdl/tilu_pkg.sv =====
// ----------------------------------------------------------------------------
// Tensor index linearizer package
// Shared widths, register indexes and lane control type.
// ----------------------------------------------------------------------------
package tilu_pkg;

  localparam int FIELD_MODES   = 4;
  localparam int COORD_FIELD_W = 32;
  localparam int INDEX_FIELD_W = 64;
  localparam int DATA_W        = INDEX_FIELD_W + FIELD_MODES * COORD_FIELD_W;

  localparam int MODE_COUNT_W  = 3;
  localparam int CFG_ADDR_W    = 3;
  localparam int CFG_DATA_W    = 64;

  localparam int MAX_MODES_DEF  = 4;
  localparam int INDEX_BITS_DEF = 64;
  localparam int COORD_BITS_DEF = 32;

  localparam logic [MODE_COUNT_W-1:0] MODE_COUNT_RST = 3'd1;

  localparam logic [CFG_ADDR_W-1:0] REG_MODE_COUNT = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_MASK_BASE  = 3'd1;

  localparam logic OP_PACK   = 1'b0;
  localparam logic OP_UNPACK = 1'b1;

  typedef struct packed {
    logic load;
    logic unpack;
    logic active;
  } lane_ctrl_t;

endpackage

// ===== hdl/tilu_lane.sv =====
// ----------------------------------------------------------------------------
// Tensor index linearizer lane
// One mode: mask bit ranks, bit deposit on pack, bit extract on unpack.
// ----------------------------------------------------------------------------
module tilu_lane #(
  parameter int INDEX_BITS = tilu_pkg::INDEX_BITS_DEF,
  parameter int COORD_BITS = tilu_pkg::COORD_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  tilu_pkg::lane_ctrl_t   ctrl_i,
  input  logic [INDEX_BITS-1:0]  mask_i,
  input  logic [INDEX_BITS-1:0]  mask_next_i,
  input  logic [COORD_BITS-1:0]  coord_i,
  input  logic [INDEX_BITS-1:0]  index_i,
  output logic [INDEX_BITS-1:0]  dep_o,
  output logic [COORD_BITS-1:0]  ext_o
);

  localparam int RANK_W = $clog2(INDEX_BITS + 1);
  localparam int LEVELS = $clog2(INDEX_BITS);
  localparam int CNT_W  = $clog2(COORD_BITS + 1);
  localparam int CMP_W  = (RANK_W > CNT_W) ? RANK_W : CNT_W;

  logic [RANK_W-1:0]                  pre [LEVELS+1][INDEX_BITS];
  logic [INDEX_BITS-1:0][RANK_W-1:0]  rank_d, rank_q;
  logic [INDEX_BITS-1:0]              dep_d, dep_q;
  logic [COORD_BITS-1:0]              ext_d, ext_q;

  // rank of each bit of the next mask = number of set bits below it (log-step scan)
  always_comb begin
    for (int b = 0; b < INDEX_BITS; b++) begin
      pre[0][b] = RANK_W'(mask_next_i[b]);
    end
    for (int l = 0; l < LEVELS; l++) begin
      for (int b = 0; b < INDEX_BITS; b++) begin
        if (b >= (1 << l)) begin
          pre[l+1][b] = pre[l][b] + pre[l][b-(1<<l)];
        end else begin
          pre[l+1][b] = pre[l][b];
        end
      end
    end
    for (int b = 0; b < INDEX_BITS; b++) begin
      rank_d[b] = pre[LEVELS][b] - RANK_W'(mask_next_i[b]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rank_q <= '0;
    end else begin
      rank_q <= rank_d;
    end
  end

  always_comb begin
    logic hit;
    dep_d = '0;
    ext_d = '0;
    hit   = 1'b0;
    for (int b = 0; b < INDEX_BITS; b++) begin
      for (int k = 0; k < COORD_BITS; k++) begin
        hit = mask_i[b] && (CMP_W'(rank_q[b]) == CMP_W'(k));
        if (hit) begin
          dep_d[b] = dep_d[b] | coord_i[k];
          ext_d[k] = ext_d[k] | index_i[b];
        end
      end
    end
    if (!ctrl_i.active) begin
      dep_d = '0;
      ext_d = '0;
    end else if (ctrl_i.unpack) begin
      dep_d = '0;
    end else begin
      ext_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      dep_q <= dep_d;
      ext_q <= ext_d;
    end
  end

  assign dep_o = dep_q;
  assign ext_o = ext_q;

endmodule

// ===== hdl/tilu_merge.sv =====
// ----------------------------------------------------------------------------
// Tensor index linearizer merge stage
// ORs lane deposits into the index, places lane extracts, output register.
// ----------------------------------------------------------------------------
module tilu_merge #(
  parameter int LANES      = tilu_pkg::MAX_MODES_DEF,
  parameter int INDEX_BITS = tilu_pkg::INDEX_BITS_DEF,
  parameter int COORD_BITS = tilu_pkg::COORD_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [INDEX_BITS-1:0]       dep_i [LANES],
  input  logic [COORD_BITS-1:0]       ext_i [LANES],
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [tilu_pkg::DATA_W-1:0] m_axis_tdata
);

  logic                        out_valid_q, out_valid_d;
  logic [tilu_pkg::DATA_W-1:0] out_data_q, out_data_d;
  logic [INDEX_BITS-1:0]       index_or;
  logic                        load;

  assign in_ready_o  = !out_valid_q || m_axis_tready;
  assign load        = in_valid_i && in_ready_o;
  assign out_valid_d = load || (out_valid_q && !m_axis_tready);

  always_comb begin
    index_or   = '0;
    out_data_d = '0;
    for (int m = 0; m < LANES; m++) begin
      index_or = index_or | dep_i[m];
      out_data_d[tilu_pkg::INDEX_FIELD_W + m*tilu_pkg::COORD_FIELD_W +: tilu_pkg::COORD_FIELD_W]
        = tilu_pkg::COORD_FIELD_W'(ext_i[m]);
    end
    out_data_d[tilu_pkg::INDEX_FIELD_W-1:0] = tilu_pkg::INDEX_FIELD_W'(index_or);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// ===== hdl/tensor_index_linearizer_unit.sv =====
// ----------------------------------------------------------------------------
// Tensor index linearizer
// Packs per-mode coordinates into a linear index (bit deposit under each
// mode mask) or unpacks an index into coordinates (bit extract).
//
// Channel     Dir  Handshake                   Payload
// s_axis      in   s_axis_tvalid/tready        tuser: operation; tdata: coords, index
// m_axis      out  m_axis_tvalid/tready        tdata: index_out, coord_out0..3
// cfg         in   cfg_we_i (no wait)          cfg_addr_i register, cfg_wdata_i value
//
// One request per cycle while m_axis_tready is high; each request passes the lane stage, then the merge stage.
// Each mode lane keeps mask bit ranks in a register, loaded from the next mask
// value, so a mask write applies to the very next request.
// A stalled output holds its register; one more request fits in the lane stage.
// Reset: mode_count 1, all masks zero, pipeline empty.
// ----------------------------------------------------------------------------
module tensor_index_linearizer_unit #(
  parameter int MAX_MODES  = tilu_pkg::MAX_MODES_DEF,
  parameter int INDEX_BITS = tilu_pkg::INDEX_BITS_DEF,
  parameter int COORD_BITS = tilu_pkg::COORD_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // coord_in0, coord_in1, coord_in2, coord_in3, index_in
  input  logic [tilu_pkg::DATA_W-1:0]     s_axis_tdata_i,
  // operation
  input  logic                            s_axis_tuser_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // index_out, coord_out0, coord_out1, coord_out2, coord_out3
  output logic [tilu_pkg::DATA_W-1:0]     m_axis_tdata_o,
  input  logic                            cfg_we_i,
  input  logic [tilu_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [tilu_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int LANES = (MAX_MODES < tilu_pkg::FIELD_MODES) ? MAX_MODES
                                                            : tilu_pkg::FIELD_MODES;

  logic [tilu_pkg::MODE_COUNT_W-1:0] mode_count_q, mode_count_d;
  logic [INDEX_BITS-1:0]             mask_q [LANES];
  logic [INDEX_BITS-1:0]             mask_d [LANES];

  logic                  s1_valid_q, s1_valid_d;
  logic                  s1_unpack_q;
  logic                  s1_load;
  logic                  merge_ready;
  tilu_pkg::lane_ctrl_t  lane_ctrl [LANES];
  logic [INDEX_BITS-1:0] dep [LANES];
  logic [COORD_BITS-1:0] ext [LANES];
  logic                  any_dep, any_ext;

  // configuration
  always_comb begin
    mode_count_d = mode_count_q;
    if (cfg_we_i && cfg_addr_i == tilu_pkg::REG_MODE_COUNT) begin
      mode_count_d = cfg_wdata_i[tilu_pkg::MODE_COUNT_W-1:0];
    end
    for (int m = 0; m < LANES; m++) begin
      mask_d[m] = mask_q[m];
      if (cfg_we_i &&
          cfg_addr_i == tilu_pkg::REG_MASK_BASE + tilu_pkg::CFG_ADDR_W'(m)) begin
        mask_d[m] = cfg_wdata_i[INDEX_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_count_q <= tilu_pkg::MODE_COUNT_RST;
      for (int m = 0; m < LANES; m++) begin
        mask_q[m] <= '0;
      end
    end else begin
      mode_count_q <= mode_count_d;
      for (int m = 0; m < LANES; m++) begin
        mask_q[m] <= mask_d[m];
      end
    end
  end

  // lane stage control
  assign s_axis_tready_o = !s1_valid_q || merge_ready;
  assign s1_load         = s_axis_tvalid_i && s_axis_tready_o;
  assign s1_valid_d      = s1_load || (s1_valid_q && !merge_ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s1_unpack_q <= tilu_pkg::OP_PACK;
    end else begin
      s1_valid_q <= s1_valid_d;
      if (s1_load) begin
        s1_unpack_q <= (s_axis_tuser_i == tilu_pkg::OP_UNPACK);
      end
    end
  end

  for (genvar m = 0; m < LANES; m++) begin : g_lane
    assign lane_ctrl[m].load   = s1_load;
    assign lane_ctrl[m].unpack = (s_axis_tuser_i == tilu_pkg::OP_UNPACK);
    assign lane_ctrl[m].active = (mode_count_q > tilu_pkg::MODE_COUNT_W'(m));

    tilu_lane #(
      .INDEX_BITS (INDEX_BITS),
      .COORD_BITS (COORD_BITS)
    ) u_lane (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (lane_ctrl[m]),
      .mask_i      (mask_q[m]),
      .mask_next_i (mask_d[m]),
      .coord_i     (s_axis_tdata_i[m*tilu_pkg::COORD_FIELD_W +: COORD_BITS]),
      .index_i     (s_axis_tdata_i[tilu_pkg::FIELD_MODES*tilu_pkg::COORD_FIELD_W +: INDEX_BITS]),
      .dep_o       (dep[m]),
      .ext_o       (ext[m])
    );
  end

  tilu_merge #(
    .LANES      (LANES),
    .INDEX_BITS (INDEX_BITS),
    .COORD_BITS (COORD_BITS)
  ) u_merge (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s1_valid_q),
    .in_ready_o    (merge_ready),
    .dep_i         (dep),
    .ext_i         (ext),
    .m_axis_tvalid (m_axis_tvalid_o),
    .m_axis_tready (m_axis_tready_i),
    .m_axis_tdata  (m_axis_tdata_o)
  );

  always_comb begin
    any_dep = 1'b0;
    any_ext = 1'b0;
    for (int m = 0; m < LANES; m++) begin
      any_dep = any_dep | (|dep[m]);
      any_ext = any_ext | (|ext[m]);
    end
  end

  // assertions
  a_ready_low_means_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> s1_valid_q)
    else $error("input stalled with empty lane stage");

  a_accept_fills_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> s1_valid_q)
    else $error("accepted request lost before lane stage");

  a_unpack_no_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s1_unpack_q |-> !any_dep)
    else $error("unpack request produced index bits");

  a_pack_no_coords: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_unpack_q |-> !any_ext)
    else $error("pack request produced coordinate bits");

endmodule
